FILE: hdl/pcv_pkg.sv
// ----------------------------------------------------------------------------
// pcv_pkg: shared types and constants of the point cloud voxelizer.
// Holds the opcode codes, the request record, the back part states and defaults.
// ----------------------------------------------------------------------------
package pcv_pkg;

	localparam int VOXEL_COUNT_DEF = 1048576;
	localparam int COORD_FRAC_BITS_DEF = 16;
	localparam int IDX_W = 20;
	localparam int COORD_W = 32;
	localparam int SIZE_W = 16;
	localparam int VPU_W = 16;
	localparam int MARGIN_W = 8;
	localparam int CFG_DATA_W = 16;

	typedef enum logic [1:0] {
		OP_WIDEN = 2'd0,
		OP_VOXEL = 2'd1,
		OP_READ  = 2'd2,
		OP_NONE  = 2'd3
	} opcode_t;

	typedef enum logic {
		CFG_VPU    = 1'b0,
		CFG_MARGIN = 1'b1
	} cfg_index_t;

	// One request as it travels from the front to the back.
	typedef struct packed {
		opcode_t            op;
		logic signed [31:0] px;
		logic signed [31:0] py;
		logic signed [31:0] pz;
		logic [IDX_W-1:0]   ridx;
	} req_t;

	// Back part state machine.
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_BOX,
		ST_SIZE,
		ST_SIZE2,
		ST_COORD,
		ST_COORD2,
		ST_LIN1,
		ST_LIN2,
		ST_LIN3,
		ST_MEM,
		ST_OUT
	} bst_t;

endpackage

FILE: hdl/pcv_front.sv
// ----------------------------------------------------------------------------
// pcv_front: input stage and request queue.
// Accepts requests, holds them in a short queue for the back part.
// ----------------------------------------------------------------------------
module pcv_front (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  pcv_pkg::req_t             in_req,
	output logic                      q_valid,
	input  logic                      q_ready,
	output pcv_pkg::req_t             q_req
);

	pcv_pkg::req_t ent_q [2];
	logic          wp_q, rp_q;
	logic [1:0]    cnt_q;

	assign in_ready = (cnt_q != 2'd2);
	assign q_valid  = (cnt_q != 2'd0);
	assign q_req    = ent_q[rp_q];

	// Queue payload.
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			ent_q[wp_q] <= in_req;
		end
	end

	// Queue pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (in_valid && in_ready) wp_q <= ~wp_q;
			if (q_valid && q_ready) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(in_valid && in_ready) - 2'(q_valid && q_ready);
		end
	end

endmodule

FILE: hdl/pcv_back.sv
// ----------------------------------------------------------------------------
// pcv_back: execution of one request at a time.
// Keeps the bounding box, computes sizes and voxel indexes, owns the
// occupancy memory with its clearing pass, and registers the result.
// ----------------------------------------------------------------------------
module pcv_back #(
	parameter int VOXEL_COUNT = pcv_pkg::VOXEL_COUNT_DEF,
	parameter int COORD_FRAC_BITS = pcv_pkg::COORD_FRAC_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      q_valid,
	output logic                      q_ready,
	input  pcv_pkg::req_t             q_req,
	input  logic [15:0]               vpu,
	input  logic [7:0]                margin,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [19:0]               voxel_index,
	output logic                      out_of_range,
	output logic                      occupied,
	output logic [15:0]               grid_size_x,
	output logic [15:0]               grid_size_y,
	output logic [15:0]               grid_size_z,
	output logic signed [31:0]        out_low_x,
	output logic signed [31:0]        out_low_y,
	output logic signed [31:0]        out_low_z,
	output logic signed [31:0]        out_high_x,
	output logic signed [31:0]        out_high_y,
	output logic signed [31:0]        out_high_z
);

	localparam int AW = $clog2(VOXEL_COUNT);

	pcv_pkg::bst_t st_q, st_d;
	pcv_pkg::req_t r_q;
	logic signed [31:0] lo_q [3];
	logic signed [31:0] hi_q [3];
	logic [15:0] sz_q [3];
	logic [33:0] c_q [3];
	logic        neg_q;
	logic [49:0] prod_q;
	logic [49:0] li_q;
	logic        mem [VOXEL_COUNT];
	logic        rd_q;
	logic [AW-1:0] clr_q;
	logic        clr_busy_q;
	logic        ok_q;

	// Products per axis, one 33x17 signed multiply each, registered.
	logic signed [49:0] ext_p [3];
	logic signed [49:0] d_p [3];
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			ext_p[k] = 50'(($signed({hi_q[k][31], hi_q[k]}) - $signed({lo_q[k][31], lo_q[k]}))
				* $signed({1'b0, vpu}));
			d_p[k] = 50'(($signed({(k == 0 ? r_q.px[31] : k == 1 ? r_q.py[31] : r_q.pz[31]),
				(k == 0 ? r_q.px : k == 1 ? r_q.py : r_q.pz)}) - $signed({lo_q[k][31], lo_q[k]}))
				* $signed({1'b0, vpu}));
		end
	end
	logic signed [49:0] ep_s1 [3];
	logic signed [49:0] dp_s1 [3];

	assign q_ready = (st_q == pcv_pkg::ST_IDLE) && !clr_busy_q;

	// Next state.
	always_comb begin
		st_d = st_q;
		case (st_q)
			pcv_pkg::ST_IDLE:   if (q_valid && q_ready) st_d = pcv_pkg::ST_BOX;
			pcv_pkg::ST_BOX:    st_d = pcv_pkg::ST_SIZE;
			pcv_pkg::ST_SIZE:   st_d = pcv_pkg::ST_SIZE2;
			pcv_pkg::ST_SIZE2:  st_d = (r_q.op == pcv_pkg::OP_VOXEL) ? pcv_pkg::ST_COORD :
				(r_q.op == pcv_pkg::OP_READ) ? pcv_pkg::ST_MEM : pcv_pkg::ST_OUT;
			pcv_pkg::ST_COORD:  st_d = pcv_pkg::ST_COORD2;
			pcv_pkg::ST_COORD2: st_d = pcv_pkg::ST_LIN1;
			pcv_pkg::ST_LIN1:   st_d = pcv_pkg::ST_LIN2;
			pcv_pkg::ST_LIN2:   st_d = pcv_pkg::ST_LIN3;
			pcv_pkg::ST_LIN3:   st_d = pcv_pkg::ST_MEM;
			pcv_pkg::ST_MEM:    st_d = pcv_pkg::ST_OUT;
			pcv_pkg::ST_OUT:    if (!out_valid || out_ready) st_d = pcv_pkg::ST_IDLE;
			default:            st_d = pcv_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= pcv_pkg::ST_IDLE;
			clr_busy_q <= 1'b1;
			clr_q <= '0;
			out_valid <= 1'b0;
			for (int k = 0; k < 3; k++) begin
				lo_q[k] <= 32'sh7FFFFFFF;
				hi_q[k] <= 32'sh80000000;
			end
		end else begin
			st_q <= st_d;
			if (clr_busy_q) begin
				clr_q <= clr_q + 1'b1;
				if (clr_q == AW'(VOXEL_COUNT - 1)) clr_busy_q <= 1'b0;
			end
			if (st_q == pcv_pkg::ST_OUT && (!out_valid || out_ready)) out_valid <= 1'b1;
			else if (out_ready) out_valid <= 1'b0;
			// Box widening.
			if (st_q == pcv_pkg::ST_BOX && r_q.op == pcv_pkg::OP_WIDEN) begin
				if (r_q.px < lo_q[0]) lo_q[0] <= r_q.px;
				if (r_q.px > hi_q[0]) hi_q[0] <= r_q.px;
				if (r_q.py < lo_q[1]) lo_q[1] <= r_q.py;
				if (r_q.py > hi_q[1]) hi_q[1] <= r_q.py;
				if (r_q.pz < lo_q[2]) lo_q[2] <= r_q.pz;
				if (r_q.pz > hi_q[2]) hi_q[2] <= r_q.pz;
			end
		end
	end

	// Datapath registers.
	logic [49:0] s_full [3];
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			s_full[k] = 50'(ep_s1[k] >>> COORD_FRAC_BITS) + 50'(margin);
		end
	end

	always_ff @(posedge clk) begin
		if (q_valid && q_ready) r_q <= q_req;
		for (int k = 0; k < 3; k++) begin
			ep_s1[k] <= ext_p[k];
			dp_s1[k] <= d_p[k] + 50'(1 << (COORD_FRAC_BITS - 1));
		end
		if (st_q == pcv_pkg::ST_SIZE2) begin
			for (int k = 0; k < 3; k++) begin
				if (lo_q[k] > hi_q[k]) sz_q[k] <= '0;
				else sz_q[k] <= (s_full[k] > 50'd65535) ? 16'hFFFF : s_full[k][15:0];
			end
		end
		if (st_q == pcv_pkg::ST_COORD2) begin
			neg_q <= dp_s1[0][49] || dp_s1[1][49] || dp_s1[2][49];
			for (int k = 0; k < 3; k++) c_q[k] <= 34'(dp_s1[k] >>> COORD_FRAC_BITS);
		end
		if (st_q == pcv_pkg::ST_LIN1) begin
			ok_q <= !neg_q && (c_q[0] < 34'(sz_q[0])) && (c_q[1] < 34'(sz_q[1]))
				&& (c_q[2] < 34'(sz_q[2]));
			prod_q <= 50'(sz_q[0] * sz_q[1]);
			li_q <= 50'(c_q[0]) + 50'(c_q[1][15:0] * sz_q[0]);
		end
		if (st_q == pcv_pkg::ST_LIN2) prod_q <= 50'(prod_q[31:0] * c_q[2][15:0]);
		if (st_q == pcv_pkg::ST_LIN3) begin
			li_q <= li_q + prod_q;
		end
		if (st_q == pcv_pkg::ST_SIZE2 && r_q.op == pcv_pkg::OP_READ) li_q <= 50'(r_q.ridx);
		if (st_q == pcv_pkg::ST_SIZE2) ok_q <= 1'b1;
		if (st_q == pcv_pkg::ST_MEM) rd_q <= mem[li_q[AW-1:0]];
	end

	logic in_store;
	assign in_store = ok_q && (li_q < 50'(VOXEL_COUNT));

	// Occupancy memory: clearing pass after reset, then set bits.
	always_ff @(posedge clk) begin
		if (clr_busy_q) mem[clr_q] <= 1'b0;
		else if (st_q == pcv_pkg::ST_MEM && r_q.op == pcv_pkg::OP_VOXEL && in_store)
			mem[li_q[AW-1:0]] <= 1'b1;
	end

	// Result register.
	always_ff @(posedge clk) begin
		if (st_q == pcv_pkg::ST_OUT && (!out_valid || out_ready)) begin
			if ((r_q.op == pcv_pkg::OP_VOXEL || r_q.op == pcv_pkg::OP_READ) && in_store) begin
				voxel_index <= li_q[19:0];
				out_of_range <= 1'b0;
				occupied <= (r_q.op == pcv_pkg::OP_VOXEL) ? 1'b1 : rd_q;
			end else begin
				voxel_index <= '0;
				out_of_range <= (r_q.op == pcv_pkg::OP_VOXEL) || (r_q.op == pcv_pkg::OP_READ);
				occupied <= 1'b0;
			end
			grid_size_x <= sz_q[0];
			grid_size_y <= sz_q[1];
			grid_size_z <= sz_q[2];
			out_low_x <= lo_q[0];
			out_low_y <= lo_q[1];
			out_low_z <= lo_q[2];
			out_high_x <= hi_q[0];
			out_high_y <= hi_q[1];
			out_high_z <= hi_q[2];
		end
	end

endmodule

FILE: hdl/point_cloud_voxelizer_core.sv
// ----------------------------------------------------------------------------
// point_cloud_voxelizer_core: occupancy grid voxelizer top level.
// ----------------------------------------------------------------------------
// Requests enter on in_valid/in_ready with an opcode, a point and a read
// index. Opcode 0 widens the bounding box, opcode 1 sets the voxel of the
// point in the occupancy memory, opcode 2 reads one occupancy bit. Each
// request gives one result on out_valid/out_ready carrying index, flags,
// grid sizes and the box.
// A two-entry queue decouples input from the back part, which runs one
// request at a time and takes no new request before the result of the
// last one is in the result register.
// After reset the occupancy memory is cleared one entry per cycle, while
// requests wait in the queue. Configuration writes (cfg_we, cfg_index,
// cfg_data) are taken at any time.
// A stalled receiver holds the result register; the back part waits and
// the queue fills, then in_ready drops.
// ----------------------------------------------------------------------------
module point_cloud_voxelizer_core #(
	parameter int VOXEL_COUNT = pcv_pkg::VOXEL_COUNT_DEF,
	parameter int COORD_FRAC_BITS = pcv_pkg::COORD_FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic [15:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         opcode,
	input  logic signed [31:0] point_x,
	input  logic signed [31:0] point_y,
	input  logic signed [31:0] point_z,
	input  logic [19:0]        read_index,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [19:0]        voxel_index,
	output logic               out_of_range,
	output logic               occupied,
	output logic [15:0]        grid_size_x,
	output logic [15:0]        grid_size_y,
	output logic [15:0]        grid_size_z,
	output logic signed [31:0] out_low_x,
	output logic signed [31:0] out_low_y,
	output logic signed [31:0] out_low_z,
	output logic signed [31:0] out_high_x,
	output logic signed [31:0] out_high_y,
	output logic signed [31:0] out_high_z
);

	logic [15:0] vpu_q;
	logic [7:0]  margin_q;
	pcv_pkg::req_t in_req, q_req;
	logic q_valid, q_ready;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vpu_q <= 16'd100;
			margin_q <= 8'd10;
		end else if (cfg_we) begin
			if (cfg_index == pcv_pkg::CFG_VPU) vpu_q <= cfg_data;
			else margin_q <= cfg_data[7:0];
		end
	end

	assign in_req = '{op: pcv_pkg::opcode_t'(opcode), px: point_x, py: point_y, pz: point_z,
		ridx: read_index};

	pcv_front u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.in_req(in_req), .q_valid(q_valid), .q_ready(q_ready), .q_req(q_req)
	);

	pcv_back #(.VOXEL_COUNT(VOXEL_COUNT), .COORD_FRAC_BITS(COORD_FRAC_BITS)) u_back (
		.clk(clk), .arst_n(arst_n), .q_valid(q_valid), .q_ready(q_ready), .q_req(q_req),
		.vpu(vpu_q), .margin(margin_q), .out_valid(out_valid), .out_ready(out_ready),
		.voxel_index(voxel_index), .out_of_range(out_of_range), .occupied(occupied),
		.grid_size_x(grid_size_x), .grid_size_y(grid_size_y), .grid_size_z(grid_size_z),
		.out_low_x(out_low_x), .out_low_y(out_low_y), .out_low_z(out_low_z),
		.out_high_x(out_high_x), .out_high_y(out_high_y), .out_high_z(out_high_z)
	);

	// An out of range result never reports an occupied voxel.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_of_range |-> !occupied && voxel_index == 20'd0)
		else $error("out of range result carries data");

	// A pending result holds while stalled.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(voxel_index))
		else $error("stalled result changed");

endmodule

FILE: sim/tb_point_cloud_voxelizer_core.sv
// ----------------------------------------------------------------------------
// tb_point_cloud_voxelizer_core: self-checking bench of the voxelizer core.
// Requests are driven with random bursts and gaps. A scoreboard class keeps
// its own bounding box, grid sizes and occupancy map, predicts every result
// and compares each returned result field by field in order.
// ----------------------------------------------------------------------------
module tb_point_cloud_voxelizer_core;

	localparam longint RUN_LIMIT = 4000000;
	localparam int SETTLE = 20;

	typedef struct {
		logic [19:0]        vidx;
		logic               oor;
		logic               occ;
		logic [15:0]        sz [3];
		logic signed [31:0] lo [3];
		logic signed [31:0] hi [3];
	} voxel_result_t;

	// Scoreboard: predicts voxelizer results and holds them until returned.
	class voxel_scoreboard;
		bit [15:0] vpu;
		bit [7:0] margin;
		int lo [3];
		int hi [3];
		bit occ_map [int];
		int hits [$];
		voxel_result_t pending_q [$];
		int errors;
		int checked;
		int oor_seen;

		function void init();
			vpu = 100;
			margin = 10;
			for (int k = 0; k < 3; k++) begin
				lo[k] = 32'h7FFFFFFF;
				hi[k] = 32'h80000000;
			end
		endfunction

		function int pending();
			return pending_q.size();
		endfunction

		function bit [15:0] axis_size(int k);
			longint ext;
			longint s;
			if (lo[k] > hi[k])
				return 16'd0;
			ext = longint'(hi[k]) - longint'(lo[k]);
			s = ((ext * longint'(vpu)) >>> pcv_pkg::COORD_FRAC_BITS_DEF) + longint'(margin);
			return (s > 65535) ? 16'hFFFF : s[15:0];
		endfunction

		// Notes one accepted request and queues the result it must produce.
		function void note_request(pcv_pkg::opcode_t op, int p [3], bit [19:0] ri);
			voxel_result_t r;
			longint c [3];
			longint d;
			longint t;
			longint li;
			bit ok;
			r.vidx = 0;
			r.oor = 0;
			r.occ = 0;
			if (op == pcv_pkg::OP_WIDEN) begin
				for (int k = 0; k < 3; k++) begin
					if (p[k] < lo[k]) lo[k] = p[k];
					if (p[k] > hi[k]) hi[k] = p[k];
				end
			end
			for (int k = 0; k < 3; k++)
				r.sz[k] = axis_size(k);
			if (op == pcv_pkg::OP_VOXEL) begin
				ok = 1;
				for (int k = 0; k < 3; k++) begin
					d = longint'(p[k]) - longint'(lo[k]);
					t = d * longint'(vpu)
						+ (longint'(1) << (pcv_pkg::COORD_FRAC_BITS_DEF - 1));
					if (t < 0) begin
						ok = 0;
					end else begin
						c[k] = t >>> pcv_pkg::COORD_FRAC_BITS_DEF;
						if (c[k] >= longint'(r.sz[k])) ok = 0;
					end
				end
				if (ok) begin
					li = c[0] + c[1] * r.sz[0] + c[2] * longint'(r.sz[0]) * longint'(r.sz[1]);
					if (li < pcv_pkg::VOXEL_COUNT_DEF) begin
						occ_map[int'(li)] = 1;
						hits = {hits, int'(li)};
						r.vidx = li[19:0];
						r.occ = 1;
					end else begin
						ok = 0;
					end
				end
				r.oor = !ok;
			end else if (op == pcv_pkg::OP_READ) begin
				if (ri < pcv_pkg::VOXEL_COUNT_DEF) begin
					r.vidx = ri;
					r.occ = occ_map.exists(int'(ri)) != 0;
				end else begin
					r.oor = 1;
				end
			end
			for (int k = 0; k < 3; k++) begin
				r.lo[k] = lo[k];
				r.hi[k] = hi[k];
			end
			pending_q = {pending_q, r};
		endfunction

		task report(string what, longint got, longint want);
			$display("MISMATCH %s: got 0x%0h, expected 0x%0h", what, got, want);
			errors++;
		endtask

		// Compares one returned result with the oldest prediction.
		task check_result(voxel_result_t g);
			voxel_result_t e;
			if (pending_q.size() == 0) begin
				$display("MISMATCH result returned with no request outstanding");
				errors++;
				return;
			end
			e = pending_q.pop_front();
			checked++;
			if (g.oor) oor_seen++;
			if (g.vidx !== e.vidx) report("voxel_index", g.vidx, e.vidx);
			if (g.oor !== e.oor) report("out_of_range", g.oor, e.oor);
			if (g.occ !== e.occ) report("occupied", g.occ, e.occ);
			for (int k = 0; k < 3; k++) begin
				if (g.sz[k] !== e.sz[k])
					report($sformatf("grid_size[%0d]", k), g.sz[k], e.sz[k]);
				if (g.lo[k] !== e.lo[k])
					report($sformatf("out_low[%0d]", k), g.lo[k], e.lo[k]);
				if (g.hi[k] !== e.hi[k])
					report($sformatf("out_high[%0d]", k), g.hi[k], e.hi[k]);
			end
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic cfg_index = 1'b0;
	logic [15:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [1:0] opcode = '0;
	logic signed [31:0] point_x = '0;
	logic signed [31:0] point_y = '0;
	logic signed [31:0] point_z = '0;
	logic [19:0] read_index = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [19:0] voxel_index;
	logic out_of_range;
	logic occupied;
	logic [15:0] grid_size_x, grid_size_y, grid_size_z;
	logic signed [31:0] out_low_x, out_low_y, out_low_z;
	logic signed [31:0] out_high_x, out_high_y, out_high_z;

	voxel_scoreboard sb = new();
	longint cycle_count = 0;
	int requests_sent = 0;
	int burst_left = 0;
	int hold_asked = 0;

	point_cloud_voxelizer_core dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.opcode(opcode), .point_x(point_x), .point_y(point_y), .point_z(point_z),
		.read_index(read_index),
		.out_valid(out_valid), .out_ready(out_ready),
		.voxel_index(voxel_index), .out_of_range(out_of_range), .occupied(occupied),
		.grid_size_x(grid_size_x), .grid_size_y(grid_size_y), .grid_size_z(grid_size_z),
		.out_low_x(out_low_x), .out_low_y(out_low_y), .out_low_z(out_low_z),
		.out_high_x(out_high_x), .out_high_y(out_high_y), .out_high_z(out_high_z)
	);

	always #5 clk = ~clk;

	// Run limit; it covers the memory clearing pass after reset.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > RUN_LIMIT) begin
			$display("Timeout after %0d cycles", cycle_count);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// Result collection on every accepted result.
	always @(posedge clk) begin
		voxel_result_t g;
		if (arst_n && out_valid && out_ready) begin
			g.vidx = voxel_index;
			g.oor = out_of_range;
			g.occ = occupied;
			g.sz[0] = grid_size_x;
			g.sz[1] = grid_size_y;
			g.sz[2] = grid_size_z;
			g.lo[0] = out_low_x;
			g.lo[1] = out_low_y;
			g.lo[2] = out_low_z;
			g.hi[0] = out_high_x;
			g.hi[1] = out_high_y;
			g.hi[2] = out_high_z;
			sb.check_result(g);
		end
	end

	// Receiver stall patterns, plus long hold-offs when the main flow asks.
	always @(negedge clk) begin
		static int mode = 0;
		static int mode_left = 0;
		static int hold_left = 0;
		static int hold_seen = 0;
		static int period = 3;
		if (hold_seen != hold_asked) begin
			hold_seen = hold_asked;
			hold_left = 300;
		end
		if (mode_left == 0) begin
			mode = $urandom_range(0, 3);
			mode_left = $urandom_range(64, 512);
			period = $urandom_range(2, 7);
		end
		mode_left--;
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			case (mode)
				0: out_ready <= 1'b1;
				1: out_ready <= 1'($urandom_range(0, 1));
				2: out_ready <= (mode_left % period) == 0;
				default: out_ready <= $urandom_range(0, 9) != 0;
			endcase
		end
	end

	// Offers one request and waits for it to be taken; gaps between bursts.
	task send_request(pcv_pkg::opcode_t op, int x, int y, int z, bit [19:0] ri);
		int p [3];
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			if ($urandom_range(0, 3) != 0) begin
				@(negedge clk);
				in_valid <= 1'b0;
				repeat ($urandom_range(0, 9)) @(negedge clk);
			end
		end
		burst_left--;
		@(negedge clk);
		in_valid <= 1'b1;
		opcode <= op;
		point_x <= x;
		point_y <= y;
		point_z <= z;
		read_index <= ri;
		do @(posedge clk); while (!in_ready);
		p[0] = x;
		p[1] = y;
		p[2] = z;
		sb.note_request(op, p, ri);
		requests_sent++;
	endtask

	task write_register(pcv_pkg::cfg_index_t idx, bit [15:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		sb.vpu = (idx == pcv_pkg::CFG_VPU) ? value : sb.vpu;
		sb.margin = (idx == pcv_pkg::CFG_MARGIN) ? value[7:0] : sb.margin;
	endtask

	// Lets every outstanding result come back, then the back end settle.
	task wait_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.pending() > 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	function int point_in_box(int k);
		longint span;
		if (sb.lo[k] > sb.hi[k])
			return int'($urandom);
		span = longint'(sb.hi[k]) - longint'(sb.lo[k]);
		if (span > 32'h7FFFFFFF) span = 32'h7FFFFFFF;
		return int'(longint'(sb.lo[k]) + $urandom_range(0, int'(span))
			- $urandom_range(0, 600));
	endfunction

	// One random request, weighted toward well-formed voxelization.
	task random_request();
		int sel;
		int x, y, z;
		bit [19:0] ri;
		sel = $urandom_range(0, 99);
		ri = 20'($urandom);
		if (sel < 12) begin
			send_request(pcv_pkg::OP_WIDEN, $urandom_range(0, 6 << 16) - (3 << 16),
				$urandom_range(0, 6 << 16) - (3 << 16),
				$urandom_range(0, 6 << 16) - (3 << 16), ri);
		end else if (sel < 60) begin
			x = point_in_box(0);
			y = point_in_box(1);
			z = ($urandom_range(0, 1) && sb.lo[2] <= sb.hi[2])
				? sb.lo[2] + $urandom_range(0, 1 << 14) : point_in_box(2);
			send_request(pcv_pkg::OP_VOXEL, x, y, z, ri);
		end else if (sel < 82) begin
			if (sb.hits.size() > 0 && $urandom_range(0, 1))
				ri = 20'(sb.hits[$urandom_range(0, sb.hits.size() - 1)]);
			send_request(pcv_pkg::OP_READ, $urandom, $urandom, $urandom, ri);
		end else if (sel < 93) begin
			send_request(pcv_pkg::OP_VOXEL, $urandom, $urandom, $urandom, ri);
		end else begin
			send_request(pcv_pkg::OP_NONE, $urandom, $urandom, $urandom, ri);
		end
	endtask

	initial begin
		bit [15:0] vpu_set [5] = '{16'd16, 16'd65535, 16'd1, 16'd3000, 16'd100};
		bit [7:0] margin_set [5] = '{8'd0, 8'd255, 8'd0, 8'd37, 8'd10};
		sb.init();
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed part at the reset register values.
		send_request(pcv_pkg::OP_VOXEL, 0, 0, 0, 0);
		send_request(pcv_pkg::OP_READ, 0, 0, 0, 20'd0);
		send_request(pcv_pkg::OP_READ, 0, 0, 0, 20'hFFFFF);
		send_request(pcv_pkg::OP_NONE, -1, -1, -1, 20'hFFFFF);
		send_request(pcv_pkg::OP_WIDEN, 0, 0, 0, 0);
		send_request(pcv_pkg::OP_WIDEN, 1 << 16, 1 << 16, 1 << 16, 0);
		send_request(pcv_pkg::OP_VOXEL, 0, 0, 0, 0);
		send_request(pcv_pkg::OP_VOXEL, 1 << 16, 1 << 16, 1 << 16, 0);
		send_request(pcv_pkg::OP_VOXEL, 1 << 16, 0, 0, 0);
		send_request(pcv_pkg::OP_VOXEL, -256, 0, 0, 0);
		send_request(pcv_pkg::OP_VOXEL, -400, 0, 0, 0);
		send_request(pcv_pkg::OP_VOXEL, 0, -(1 << 16), 0, 0);
		send_request(pcv_pkg::OP_VOXEL, 2 << 16, 0, 0, 0);
		send_request(pcv_pkg::OP_VOXEL, 327, 328, 0, 0);
		send_request(pcv_pkg::OP_VOXEL, 32'h80000000, 32'h80000000, 32'h80000000, 0);
		send_request(pcv_pkg::OP_VOXEL, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 0);
		send_request(pcv_pkg::OP_READ, 0, 0, 0, 20'd0);
		send_request(pcv_pkg::OP_READ, 0, 0, 0, 20'd100);
		wait_drained();

		// Random phases, each under its own register setting.
		for (int ph = 0; ph < 5; ph++) begin
			write_register(pcv_pkg::CFG_VPU, vpu_set[ph]);
			write_register(pcv_pkg::CFG_MARGIN, margin_set[ph]);
			for (int n = 0; n < 180; n++) begin
				if (n == 60 && ph % 2 == 0)
					hold_asked++;
				random_request();
			end
			wait_drained();
		end

		// Widen to the coordinate extremes, then a short random tail.
		send_request(pcv_pkg::OP_WIDEN, 32'h80000000, 32'h7FFFFFFF, 32'h80000000, 0);
		send_request(pcv_pkg::OP_WIDEN, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 0);
		for (int n = 0; n < 30; n++)
			random_request();
		wait_drained();

		$display("Sent %0d requests; checked %0d results, %0d out of range.",
			requests_sent, sb.checked, sb.oor_seen);
		$display("Covered %0d register settings and %0d voxel writes.",
			6, sb.hits.size());
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
